// ===== rtl/core/tbo_pkg.sv =====
// Shared constants for the triangle/box overlap pipeline.
// Used by the top level and the testbench; no dependencies.
package tbo_pkg;

  localparam int unsigned NUM_REGS = 3;

  localparam logic [1:0] REG_HALF_X = 2'd0;
  localparam logic [1:0] REG_HALF_Y = 2'd1;
  localparam logic [1:0] REG_HALF_Z = 2'd2;

  localparam int unsigned NUM_CROSS_AXES = 9;

endpackage

// ===== rtl/core/tbo_axis_test.sv =====
// Separating-axis decision for one edge-by-axis cross test.
// Takes registered projection and radius products; no package dependencies.
module tbo_axis_test #(
  parameter int PW = 52
) (
  input  logic signed [PW-1:0] p0,
  input  logic signed [PW-1:0] p1,
  input  logic signed [PW-1:0] q0,
  input  logic signed [PW-1:0] q1,
  input  logic signed [PW-1:0] r0,
  input  logic signed [PW-1:0] r1,
  output logic                 separates
);

  logic signed [PW:0] p;
  logic signed [PW:0] q;
  logic signed [PW:0] rad;
  logic signed [PW:0] nrad;

  always_comb begin
    p    = (PW+1)'(p0) + (PW+1)'(p1);
    q    = (PW+1)'(q0) + (PW+1)'(q1);
    rad  = (PW+1)'(r0) + (PW+1)'(r1);
    nrad = -rad;
    separates = ((p < nrad) && (q < nrad)) || ((rad < p) && (rad < q));
  end

endmodule

// ===== rtl/core/triangle_box_overlap_test.sv =====
// Triangle / axis-aligned box overlap test, separating-axis form, Q12.12 fixed point.
// Throughput one item per cycle unless a low out_ready holds the output and stalls the pipeline.
// Depth is set by the eight register stages: offsets, edges, axis products, axis verdicts,
// normal magnitude, split partial products of the plane terms, product assembly, plane sum.
// Reset (rst, synchronous): clears all stage valid bits and the half-size registers to 0.
// Depends on tbo_pkg and tbo_axis_test.
module triangle_box_overlap_test #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_z,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_z,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          overlaps
);

  localparam int CW  = COORD_WIDTH;
  localparam int HW  = CW - 1;
  localparam int RW  = CW + 1;
  localparam int EW  = CW + 2;
  localparam int KW  = CW + 3;
  localparam int PW  = KW + RW;
  localparam int NW  = 2 * EW + 1;
  localparam int L   = CW + 3;
  localparam int FW  = NW + RW + 2;
  localparam int DW  = FW + 2;
  localparam int NS  = 8;
  localparam int NA  = tbo_pkg::NUM_CROSS_AXES;

  // configuration
  logic [HW-1:0] half_size_x;
  logic [HW-1:0] half_size_y;
  logic [HW-1:0] half_size_z;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_size_x <= '0;
      half_size_y <= '0;
      half_size_z <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        tbo_pkg::REG_HALF_X: half_size_x <= pwdata[HW-1:0];
        tbo_pkg::REG_HALF_Y: half_size_y <= pwdata[HW-1:0];
        tbo_pkg::REG_HALF_Z: half_size_z <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tbo_pkg::REG_HALF_X: prdata = 32'(half_size_x);
      tbo_pkg::REG_HALF_Y: prdata = 32'(half_size_y);
      tbo_pkg::REG_HALF_Z: prdata = 32'(half_size_z);
      default:             prdata = '0;
    endcase
  end

  // pipeline flow control
  logic [NS:1] vld;
  logic [NS:1] adv;

  always_comb begin
    adv[NS] = !vld[NS] || out_ready;
    for (int i = NS - 1; i >= 1; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= in_valid;
      for (int i = 2; i <= NS; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld[NS];

  // stage 1: offsets from box center (a xyz, b xyz, c xyz)
  logic signed [RW-1:0] s1_rel [9];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_rel[0] <= RW'(vertex_a_x) - RW'(center_x);
      s1_rel[1] <= RW'(vertex_a_y) - RW'(center_y);
      s1_rel[2] <= RW'(vertex_a_z) - RW'(center_z);
      s1_rel[3] <= RW'(vertex_b_x) - RW'(center_x);
      s1_rel[4] <= RW'(vertex_b_y) - RW'(center_y);
      s1_rel[5] <= RW'(vertex_b_z) - RW'(center_z);
      s1_rel[6] <= RW'(vertex_c_x) - RW'(center_x);
      s1_rel[7] <= RW'(vertex_c_y) - RW'(center_y);
      s1_rel[8] <= RW'(vertex_c_z) - RW'(center_z);
    end
  end

  // stage 2: edges and bounding-box axes
  logic signed [RW-1:0] s2_rel [9];
  logic signed [EW-1:0] s2_e   [9];
  logic                 s2_sep;
  logic signed [RW-1:0] hs     [3];
  logic                 box_sep;

  assign hs[0] = signed'(RW'(half_size_x));
  assign hs[1] = signed'(RW'(half_size_y));
  assign hs[2] = signed'(RW'(half_size_z));

  always_comb begin
    box_sep = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if ((s1_rel[c] > hs[c]) && (s1_rel[3+c] > hs[c]) && (s1_rel[6+c] > hs[c])) box_sep = 1'b1;
      if ((s1_rel[c] < -hs[c]) && (s1_rel[3+c] < -hs[c]) && (s1_rel[6+c] < -hs[c]))
        box_sep = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int c = 0; c < 3; c++) begin
        s2_e[c]   <= EW'(s1_rel[3+c]) - EW'(s1_rel[c]);
        s2_e[3+c] <= EW'(s1_rel[6+c]) - EW'(s1_rel[3+c]);
        s2_e[6+c] <= EW'(s1_rel[c])   - EW'(s1_rel[6+c]);
      end
      s2_rel <= s1_rel;
      s2_sep <= box_sep;
    end
  end

  // stage 3: cross-axis products and normal products
  logic signed [KW-1:0] k0 [NA];
  logic signed [KW-1:0] k1 [NA];
  logic signed [KW:0]   k0a [NA];
  logic signed [KW:0]   k1a [NA];
  logic signed [RW-1:0] u0 [NA];
  logic signed [RW-1:0] u1 [NA];
  logic signed [RW-1:0] w0 [NA];
  logic signed [RW-1:0] w1 [NA];
  logic signed [CW-1:0] r0 [NA];
  logic signed [CW-1:0] r1 [NA];

  function automatic logic signed [KW-1:0] kx(input logic signed [EW-1:0] e, input logic neg);
    logic signed [KW-1:0] v;
    v = KW'(e);
    return neg ? -v : v;
  endfunction

  always_comb begin
    // x cross edges over (y, z)
    for (int i = 0; i < 3; i++) begin
      k0[i] = kx(s2_e[3*i+2], 1'b1);
      k1[i] = kx(s2_e[3*i+1], 1'b0);
      u0[i] = s2_rel[1];
      u1[i] = s2_rel[2];
      w0[i] = (i == 2) ? s2_rel[4] : s2_rel[7];
      w1[i] = (i == 2) ? s2_rel[5] : s2_rel[8];
      r0[i] = signed'(CW'(half_size_y));
      r1[i] = signed'(CW'(half_size_z));
    end
    // y cross edges over (x, z)
    for (int i = 0; i < 3; i++) begin
      k0[3+i] = kx(s2_e[3*i+2], 1'b0);
      k1[3+i] = kx(s2_e[3*i], 1'b1);
      u0[3+i] = s2_rel[0];
      u1[3+i] = s2_rel[2];
      w0[3+i] = (i == 2) ? s2_rel[3] : s2_rel[6];
      w1[3+i] = (i == 2) ? s2_rel[5] : s2_rel[8];
      r0[3+i] = signed'(CW'(half_size_x));
      r1[3+i] = signed'(CW'(half_size_z));
    end
    // z cross edges over (x, y)
    for (int i = 0; i < 3; i++) begin
      k0[6+i] = kx(s2_e[3*i+1], 1'b1);
      k1[6+i] = kx(s2_e[3*i], 1'b0);
      r0[6+i] = signed'(CW'(half_size_x));
      r1[6+i] = signed'(CW'(half_size_y));
    end
    u0[6] = s2_rel[3];
    u1[6] = s2_rel[4];
    w0[6] = s2_rel[6];
    w1[6] = s2_rel[7];
    u0[7] = s2_rel[0];
    u1[7] = s2_rel[1];
    w0[7] = s2_rel[3];
    w1[7] = s2_rel[4];
    u0[8] = s2_rel[3];
    u1[8] = s2_rel[4];
    w0[8] = s2_rel[6];
    w1[8] = s2_rel[7];
    for (int i = 0; i < NA; i++) begin
      k0a[i] = k0[i][KW-1] ? -(KW+1)'(k0[i]) : (KW+1)'(k0[i]);
      k1a[i] = k1[i][KW-1] ? -(KW+1)'(k1[i]) : (KW+1)'(k1[i]);
    end
  end

  logic signed [PW-1:0]   s3_p0 [NA];
  logic signed [PW-1:0]   s3_p1 [NA];
  logic signed [PW-1:0]   s3_q0 [NA];
  logic signed [PW-1:0]   s3_q1 [NA];
  logic signed [PW-1:0]   s3_r0 [NA];
  logic signed [PW-1:0]   s3_r1 [NA];
  logic signed [2*EW-1:0] s3_np [6];
  logic signed [RW-1:0]   s3_ra [3];
  logic                   s3_sep;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < NA; i++) begin
        s3_p0[i] <= k0[i] * PW'(u0[i]);
        s3_p1[i] <= k1[i] * PW'(u1[i]);
        s3_q0[i] <= k0[i] * PW'(w0[i]);
        s3_q1[i] <= k1[i] * PW'(w1[i]);
        s3_r0[i] <= k0a[i] * PW'(r0[i]);
        s3_r1[i] <= k1a[i] * PW'(r1[i]);
      end
      s3_np[0] <= s2_e[1] * s2_e[5];
      s3_np[1] <= s2_e[2] * s2_e[4];
      s3_np[2] <= s2_e[2] * s2_e[3];
      s3_np[3] <= s2_e[0] * s2_e[5];
      s3_np[4] <= s2_e[0] * s2_e[4];
      s3_np[5] <= s2_e[1] * s2_e[3];
      for (int c = 0; c < 3; c++) begin
        s3_ra[c] <= s2_rel[c];
      end
      s3_sep   <= s2_sep;
    end
  end

  // stage 4: cross-axis verdicts and triangle normal
  logic [NA-1:0] axis_sep;

  for (genvar g = 0; g < NA; g++) begin : g_axis
    tbo_axis_test #(.PW(PW)) u_axis (
      .p0       (s3_p0[g]),
      .p1       (s3_p1[g]),
      .q0       (s3_q0[g]),
      .q1       (s3_q1[g]),
      .r0       (s3_r0[g]),
      .r1       (s3_r1[g]),
      .separates(axis_sep[g])
    );
  end

  logic signed [NW-1:0] s4_n  [3];
  logic signed [RW-1:0] s4_ra [3];
  logic                 s4_sep;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int c = 0; c < 3; c++) begin
        s4_n[c] <= NW'(s3_np[2*c]) - NW'(s3_np[2*c+1]);
      end
      s4_ra  <= s3_ra;
      s4_sep <= s3_sep || (|axis_sep);
    end
  end

  // stage 5: normal magnitude
  logic signed [NW-1:0] s5_n  [3];
  logic signed [NW:0]   s5_na [3];
  logic signed [RW-1:0] s5_ra [3];
  logic                 s5_sep;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int c = 0; c < 3; c++) begin
        s5_na[c] <= s4_n[c][NW-1] ? -(NW+1)'(s4_n[c]) : (NW+1)'(s4_n[c]);
      end
      s5_n   <= s4_n;
      s5_ra  <= s4_ra;
      s5_sep <= s4_sep;
    end
  end

  // stage 6: split partial products of the plane terms
  logic signed [L+RW:0]     s6_dlo [3];
  logic signed [NW-L+RW-1:0] s6_dhi [3];
  logic signed [L+CW:0]     s6_rlo [3];
  logic signed [NW-L+CW:0]  s6_rhi [3];
  logic signed [CW-1:0]     hsz    [3];
  logic                     s6_sep;

  assign hsz[0] = signed'(CW'(half_size_x));
  assign hsz[1] = signed'(CW'(half_size_y));
  assign hsz[2] = signed'(CW'(half_size_z));

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int c = 0; c < 3; c++) begin
        s6_dlo[c] <= signed'({1'b0, s5_n[c][L-1:0]}) * (L+RW+1)'(s5_ra[c]);
        s6_dhi[c] <= signed'(s5_n[c][NW-1:L]) * (NW-L+RW)'(s5_ra[c]);
        s6_rlo[c] <= signed'({1'b0, s5_na[c][L-1:0]}) * (L+CW+1)'(hsz[c]);
        s6_rhi[c] <= signed'(s5_na[c][NW:L]) * (NW-L+CW+1)'(hsz[c]);
      end
      s6_sep <= s5_sep;
    end
  end

  // stage 7: assemble full products
  logic signed [FW-1:0] s7_d [3];
  logic signed [FW-1:0] s7_r [3];
  logic                 s7_sep;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int c = 0; c < 3; c++) begin
        s7_d[c] <= (FW'(s6_dhi[c]) <<< L) + FW'(s6_dlo[c]);
        s7_r[c] <= (FW'(s6_rhi[c]) <<< L) + FW'(s6_rlo[c]);
      end
      s7_sep <= s6_sep;
    end
  end

  // stage 8: plane test and verdict
  logic signed [DW-1:0] dot;
  logic signed [DW-1:0] rad;
  logic                 plane_sep;

  always_comb begin
    dot = DW'(s7_d[0]) + DW'(s7_d[1]) + DW'(s7_d[2]);
    rad = DW'(s7_r[0]) + DW'(s7_r[1]) + DW'(s7_r[2]);
    plane_sep = ((dot + rad) < 0) || (dot > rad);
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      overlaps <= !(s7_sep || plane_sep);
    end
  end

`ifndef SYNTHESIS
  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_flow : assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while the pipeline can drain");
  a_cfg_hold : assert property (@(posedge clk) disable iff (rst)
    !cfg_write |=> ($stable(half_size_x) && $stable(half_size_y) && $stable(half_size_z)))
    else $error("half size changed without a write");
`endif

endmodule
